// ===== rtl/core/bsr_pkg.sv =====
// package: shared constants, types and codes of the bilinear slice resampler
`timescale 1ns / 1ps
package bsr_pkg;

    // volume and image limits
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_DEPTH  = 16;
    localparam int MAX_DEST   = 1024;

    // field widths
    localparam int X_W    = 6;
    localparam int Y_W    = 6;
    localparam int Z_W    = 4;
    localparam int VOX_W  = 8;
    localparam int DX_W   = 10;
    localparam int ADDR_W = Z_W + Y_W + X_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int SW_W       = 7;
    localparam int SD_W       = 5;
    localparam int DW_W       = 11;

    // arithmetic widths
    localparam int AXN_W = DX_W + X_W;     // x*(sw-1)
    localparam int AXD_W = DX_W;           // dw-1
    localparam int AXQ_W = X_W;            // cell index
    localparam int WGT_W = 2 * AXD_W;      // weight products and H
    localparam int SUM_W = WGT_W + VOX_W;  // weighted sum
    localparam int HQ_W  = VOX_W;          // final quotient

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_SRC_DEPTH  = 3'd2,
        CFG_DST_WIDTH  = 3'd3,
        CFG_DST_HEIGHT = 3'd4
    } t_cfg_idx;

    // control that travels with each beat down the pipeline
    typedef struct packed {
        logic wr;   // voxel write to commit
        logic smp;  // sample that yields a result
        logic err;  // sample out of range
    } t_ctl;

endpackage

// ===== rtl/core/bsr_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module bsr_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 10,
    parameter int Q_W   = 6
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo,
    output logic [NUM_W-1:0] o_rem
);

    localparam int CW = NUM_W + DEN_W + Q_W;

    logic [NUM_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];
    logic [DEN_W-1:0] r_den [Q_W-1];

    for (genvar k = 0; k < Q_W; k++) begin : g_stg
        localparam int B = Q_W - 1 - k;
        logic [NUM_W-1:0] rem_in;
        logic [Q_W-1:0]   quo_in;
        logic [DEN_W-1:0] den_in;
        logic [CW-1:0]    shifted;
        logic             ge;

        // stage inputs
        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
        end

        // trial subtract of the shifted divisor
        assign shifted = CW'(den_in) << B;
        assign ge      = CW'(rem_in) >= shifted;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? NUM_W'(CW'(rem_in) - shifted) : rem_in;
                r_quo[k] <= quo_in | (ge ? (Q_W'(1) << B) : Q_W'(0));
            end
        end

        // divisor follows the beat into the next stage
        if (k < Q_W - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];
    assign o_rem = r_rem[Q_W-1];

endmodule

// ===== rtl/core/bsr_vol_mem.sv =====
// volume store: four banks split by row and column parity, one read each per beat
`timescale 1ns / 1ps
module bsr_vol_mem (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic                      i_wr,
    input  logic [bsr_pkg::ADDR_W-1:0] i_waddr,
    input  logic [bsr_pkg::VOX_W-1:0]  i_wdata,
    input  logic [bsr_pkg::Z_W-1:0]    i_rz,
    input  logic [bsr_pkg::X_W-1:0]    i_ri,
    input  logic [bsr_pkg::Y_W-1:0]    i_rj,
    output logic [bsr_pkg::VOX_W-1:0]  o_v00,
    output logic [bsr_pkg::VOX_W-1:0]  o_v10,
    output logic [bsr_pkg::VOX_W-1:0]  o_v01,
    output logic [bsr_pkg::VOX_W-1:0]  o_v11
);

    localparam int XW      = bsr_pkg::X_W;
    localparam int YW      = bsr_pkg::Y_W;
    localparam int BANK_AW = bsr_pkg::Z_W + XW - 1 + YW - 1;
    localparam int BANK_D  = 1 << BANK_AW;

    logic [bsr_pkg::X_W-1:0]   wx;
    logic [bsr_pkg::Y_W-1:0]   wy;
    logic [bsr_pkg::Z_W-1:0]   wz;
    logic [BANK_AW-1:0]        wa;
    logic [bsr_pkg::VOX_W-1:0] w_q [4];
    logic [1:0]                r_par;

    // write address split into bank and in-bank address
    assign wx = i_waddr[XW-1:0];
    assign wy = i_waddr[XW+YW-1:XW];
    assign wz = i_waddr[bsr_pkg::ADDR_W-1:XW+YW];
    assign wa = {wz, wy[YW-1:1], wx[XW-1:1]};

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'(b / 2);
        logic [bsr_pkg::X_W-1:0]   xc;
        logic [bsr_pkg::Y_W-1:0]   yc;
        logic [BANK_AW-1:0]        ra;
        logic                      wsel;
        logic [bsr_pkg::VOX_W-1:0] mem [BANK_D];
        logic [bsr_pkg::VOX_W-1:0] r_q;

        // neighbour of matching parity
        assign xc   = (i_ri[0] == PX) ? i_ri : XW'(i_ri + XW'(1));
        assign yc   = (i_rj[0] == PY) ? i_rj : YW'(i_rj + YW'(1));
        assign ra   = {i_rz, yc[YW-1:1], xc[XW-1:1]};
        assign wsel = i_wr && (wx[0] == PX) && (wy[0] == PY);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (wsel) begin
                    mem[wa] <= i_wdata;
                end
                r_q <= mem[ra];
            end
        end

        assign w_q[b] = r_q;
    end

    // parity of the base cell, to route banks back to corners
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_par <= {i_rj[0], i_ri[0]};
        end
    end

    assign o_v00 = w_q[{r_par[1],  r_par[0]}];
    assign o_v10 = w_q[{r_par[1], ~r_par[0]}];
    assign o_v01 = w_q[{~r_par[1],  r_par[0]}];
    assign o_v11 = w_q[{~r_par[1], ~r_par[0]}];

endmodule

// ===== rtl/core/bilinear_slice_resampler_top.sv =====
// top level: configuration, pipeline control and bilinear arithmetic
//
//  channel   direction  handshake                  payload
//  in        to block   i_in_valid / o_in_ready    command, write and sample fields
//  out       from block o_out_valid / i_out_ready  o_pixel_value, o_range_error
//  cfg       to block   i_cfg_we                   i_cfg_index, i_cfg_data
//
// one beat per cycle unless the output stalls; a sample yields one result on the out channel,
// a write commits to the volume at the volume stage and gives no result.
// beats pass through the two axis dividers (6 stages) and the normalising divider
// (8 stages), with the registered volume read between them.
// reset restores the size registers; the volume content is undefined until written.
// a stalled output holds the whole pipeline; o_in_ready follows that stall.
`timescale 1ns / 1ps
module bilinear_slice_resampler_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [bsr_pkg::X_W-1:0]       i_write_x,
    input  logic [bsr_pkg::Y_W-1:0]       i_write_y,
    input  logic [bsr_pkg::Z_W-1:0]       i_write_z,
    input  logic [bsr_pkg::VOX_W-1:0]     i_voxel_value,
    input  logic [bsr_pkg::Z_W-1:0]       i_slice,
    input  logic [bsr_pkg::DX_W-1:0]      i_dest_x,
    input  logic [bsr_pkg::DX_W-1:0]      i_dest_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bsr_pkg::VOX_W-1:0]     o_pixel_value,
    output logic                          o_range_error,
    input  logic                          i_cfg_we,
    input  logic [bsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AL = bsr_pkg::AXQ_W;
    localparam int HL = bsr_pkg::HQ_W;
    localparam int SW = bsr_pkg::SW_W;
    localparam int SD = bsr_pkg::SD_W;
    localparam int DW = bsr_pkg::DW_W;
    localparam int XW = bsr_pkg::X_W;
    localparam int AD = bsr_pkg::AXD_W;
    localparam int AN = bsr_pkg::AXN_W;
    localparam int WG = bsr_pkg::WGT_W;
    localparam int SM = bsr_pkg::SUM_W;
    localparam int VW = bsr_pkg::VOX_W;

    logic en;

    // size registers, held clamped
    logic [SW-1:0] r_sw, r_sh;
    logic [SD-1:0] r_sd;
    logic [DW-1:0] r_dw, r_dh;
    logic [SW-1:0] n_sw, n_sh;
    logic [SD-1:0] n_sd;
    logic [DW-1:0] n_dw, n_dh;
    logic [XW-1:0] swm1, shm1;
    logic [AD-1:0] hx, hy;
    logic [WG-1:0] r_hprod;

    // clamp incoming register values
    always_comb begin
        n_sw = i_cfg_data[SW-1:0];
        if (n_sw < SW'(2)) n_sw = SW'(2);
        if (n_sw > SW'(bsr_pkg::MAX_WIDTH)) n_sw = SW'(bsr_pkg::MAX_WIDTH);
        n_sh = i_cfg_data[SW-1:0];
        if (n_sh < SW'(2)) n_sh = SW'(2);
        if (n_sh > SW'(bsr_pkg::MAX_HEIGHT)) n_sh = SW'(bsr_pkg::MAX_HEIGHT);
        n_sd = i_cfg_data[SD-1:0];
        if (n_sd < SD'(1)) n_sd = SD'(1);
        if (n_sd > SD'(bsr_pkg::MAX_DEPTH)) n_sd = SD'(bsr_pkg::MAX_DEPTH);
        n_dw = i_cfg_data[DW-1:0];
        if (n_dw < DW'(2)) n_dw = DW'(2);
        if (n_dw > DW'(bsr_pkg::MAX_DEST)) n_dw = DW'(bsr_pkg::MAX_DEST);
        n_dh = i_cfg_data[DW-1:0];
        if (n_dh < DW'(2)) n_dh = DW'(2);
        if (n_dh > DW'(bsr_pkg::MAX_DEST)) n_dh = DW'(bsr_pkg::MAX_DEST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= SW'(64);
            r_sh <= SW'(64);
            r_sd <= SD'(16);
            r_dw <= DW'(64);
            r_dh <= DW'(64);
        end else if (i_cfg_we) begin
            unique case (bsr_pkg::t_cfg_idx'(i_cfg_index))
                bsr_pkg::CFG_SRC_WIDTH:  r_sw <= n_sw;
                bsr_pkg::CFG_SRC_HEIGHT: r_sh <= n_sh;
                bsr_pkg::CFG_SRC_DEPTH:  r_sd <= n_sd;
                bsr_pkg::CFG_DST_WIDTH:  r_dw <= n_dw;
                bsr_pkg::CFG_DST_HEIGHT: r_dh <= n_dh;
                default: ;
            endcase
        end
    end

    assign swm1 = XW'(r_sw - SW'(1));
    assign shm1 = XW'(r_sh - SW'(1));
    assign hx   = AD'(r_dw - DW'(1));
    assign hy   = AD'(r_dh - DW'(1));

    // normalising divisor
    always_ff @(posedge i_clk) begin
        r_hprod <= WG'(hx) * WG'(hy);
    end

    // global advance: the output register frees the pipeline
    logic r_out_vld;
    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // stage 1: capture, range checks, axis numerators
    bsr_pkg::t_ctl r1_ctl;
    logic [AN-1:0] r1_numx, r1_numy;
    logic [bsr_pkg::ADDR_W-1:0] r1_waddr;
    logic [VW-1:0] r1_wdata;
    logic [bsr_pkg::Z_W-1:0] r1_z;
    logic s_err, s_wok;

    assign s_err = (SD'(i_slice) >= r_sd) || (DW'(i_dest_x) >= r_dw) ||
                   (DW'(i_dest_y) >= r_dh);
    assign s_wok = (SW'(i_write_x) < r_sw) && (SW'(i_write_y) < r_sh) &&
                   (SD'(i_write_z) < r_sd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (en) begin
            r1_ctl.wr  <= i_in_valid && !i_command && s_wok;
            r1_ctl.smp <= i_in_valid && i_command;
            r1_ctl.err <= s_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_numx  <= AN'(i_dest_x) * AN'(swm1);
            r1_numy  <= AN'(i_dest_y) * AN'(shm1);
            r1_waddr <= {i_write_z, i_write_y, i_write_x};
            r1_wdata <= i_voxel_value;
            r1_z     <= i_slice;
        end
    end

    // axis dividers
    logic [AL-1:0] qx, qy;
    logic [AN-1:0] remx, remy;

    bsr_div #(.NUM_W(AN), .DEN_W(AD), .Q_W(AL)) u_div_x (
        .i_clk (i_clk), .i_en (en), .i_num (r1_numx), .i_den (hx),
        .o_quo (qx), .o_rem (remx)
    );

    bsr_div #(.NUM_W(AN), .DEN_W(AD), .Q_W(AL)) u_div_y (
        .i_clk (i_clk), .i_en (en), .i_num (r1_numy), .i_den (hy),
        .o_quo (qy), .o_rem (remy)
    );

    // side delay line alongside the axis dividers
    bsr_pkg::t_ctl r_dl_ctl [AL];
    logic [bsr_pkg::ADDR_W-1:0] r_dl_waddr [AL];
    logic [VW-1:0] r_dl_wdata [AL];
    logic [bsr_pkg::Z_W-1:0] r_dl_z [AL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AL; k++) r_dl_ctl[k] <= '0;
        end else if (en) begin
            r_dl_ctl[0] <= r1_ctl;
            for (int k = 1; k < AL; k++) r_dl_ctl[k] <= r_dl_ctl[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_waddr[0] <= r1_waddr;
            r_dl_wdata[0] <= r1_wdata;
            r_dl_z[0]     <= r1_z;
            for (int k = 1; k < AL; k++) begin
                r_dl_waddr[k] <= r_dl_waddr[k-1];
                r_dl_wdata[k] <= r_dl_wdata[k-1];
                r_dl_z[k]     <= r_dl_z[k-1];
            end
        end
    end

    // stage 8: base cell and offset from quotient and remainder
    logic [AD-1:0] rx, ry;
    logic [AL-1:0] n_i0, n_j0;
    logic [AD-1:0] n_w, n_h;

    assign rx = AD'(remx);
    assign ry = AD'(remy);

    always_comb begin
        if (rx != '0) begin
            n_i0 = qx;
            n_w  = rx;
        end else if (qx != '0) begin
            n_i0 = AL'(qx - AL'(1));
            n_w  = hx;
        end else begin
            n_i0 = '0;
            n_w  = '0;
        end
        if (ry != '0) begin
            n_j0 = qy;
            n_h  = ry;
        end else if (qy != '0) begin
            n_j0 = AL'(qy - AL'(1));
            n_h  = hy;
        end else begin
            n_j0 = '0;
            n_h  = '0;
        end
    end

    bsr_pkg::t_ctl r8_ctl;
    logic [AL-1:0] r8_i0, r8_j0;
    logic [AD-1:0] r8_w, r8_h;
    logic [bsr_pkg::ADDR_W-1:0] r8_waddr;
    logic [VW-1:0] r8_wdata;
    logic [bsr_pkg::Z_W-1:0] r8_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_ctl <= '0;
        end else if (en) begin
            r8_ctl <= r_dl_ctl[AL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_i0    <= n_i0;
            r8_j0    <= n_j0;
            r8_w     <= n_w;
            r8_h     <= n_h;
            r8_waddr <= r_dl_waddr[AL-1];
            r8_wdata <= r_dl_wdata[AL-1];
            r8_z     <= r_dl_z[AL-1];
        end
    end

    // volume access: writes commit here, samples read four corners
    logic [VW-1:0] v00, v10, v01, v11;

    bsr_vol_mem u_mem (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_wr    (r8_ctl.wr),
        .i_waddr (r8_waddr),
        .i_wdata (r8_wdata),
        .i_rz    (r8_z),
        .i_ri    (r8_i0),
        .i_rj    (r8_j0),
        .o_v00   (v00),
        .o_v10   (v10),
        .o_v01   (v01),
        .o_v11   (v11)
    );

    // stage 9: offsets alongside the read data
    bsr_pkg::t_ctl r9_ctl;
    logic [AD-1:0] r9_w, r9_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_ctl <= '0;
        end else if (en) begin
            r9_ctl <= r8_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_w <= r8_w;
            r9_h <= r8_h;
        end
    end

    // stage 10: corner weights
    bsr_pkg::t_ctl r10_ctl;
    logic [WG-1:0] r10_a00, r10_a10, r10_a01, r10_a11;
    logic [VW-1:0] r10_v00, r10_v10, r10_v01, r10_v11;
    logic [AD-1:0] wx_c, hy_c;

    assign wx_c = AD'(hx - r9_w);
    assign hy_c = AD'(hy - r9_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_ctl <= '0;
        end else if (en) begin
            r10_ctl <= r9_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_a00 <= WG'(wx_c) * WG'(hy_c);
            r10_a10 <= WG'(r9_w) * WG'(hy_c);
            r10_a01 <= WG'(wx_c) * WG'(r9_h);
            r10_a11 <= WG'(r9_w) * WG'(r9_h);
            r10_v00 <= v00;
            r10_v10 <= v10;
            r10_v01 <= v01;
            r10_v11 <= v11;
        end
    end

    // stage 11: weighted corners
    bsr_pkg::t_ctl r11_ctl;
    logic [SM-1:0] r11_p00, r11_p10, r11_p01, r11_p11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_ctl <= '0;
        end else if (en) begin
            r11_ctl <= r10_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_p00 <= SM'(r10_a00) * SM'(r10_v00);
            r11_p10 <= SM'(r10_a10) * SM'(r10_v10);
            r11_p01 <= SM'(r10_a01) * SM'(r10_v01);
            r11_p11 <= SM'(r10_a11) * SM'(r10_v11);
        end
    end

    // stage 12: sum of the four corners
    bsr_pkg::t_ctl r12_ctl;
    logic [SM-1:0] r12_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_ctl <= '0;
        end else if (en) begin
            r12_ctl <= r11_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_sum <= SM'(r11_p00 + r11_p10 + r11_p01 + r11_p11);
        end
    end

    // normalising divider
    logic [HL-1:0] quo;

    bsr_div #(.NUM_W(SM), .DEN_W(WG), .Q_W(HL)) u_div_h (
        .i_clk (i_clk), .i_en (en), .i_num (r12_sum), .i_den (r_hprod),
        .o_quo (quo), .o_rem ()
    );

    bsr_pkg::t_ctl r_dq_ctl [HL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HL; k++) r_dq_ctl[k] <= '0;
        end else if (en) begin
            r_dq_ctl[0] <= r12_ctl;
            for (int k = 1; k < HL; k++) r_dq_ctl[k] <= r_dq_ctl[k-1];
        end
    end

    // output register
    logic [VW-1:0] r_out_pix;
    logic          r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dq_ctl[HL-1].smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pix <= r_dq_ctl[HL-1].err ? VW'(0) : VW'(quo);
            r_out_err <= r_dq_ctl[HL-1].err;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_pixel_value = r_out_pix;
    assign o_range_error = r_out_err;

    // source and destination width registers never leave their legal range
    a_cfg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sw >= SW'(2) && r_sw <= SW'(bsr_pkg::MAX_WIDTH) &&
        r_dw >= DW'(2) && r_dw <= DW'(bsr_pkg::MAX_DEST))
        else $error("size register out of range");

    // a beat at the volume is a write or a sample, never both
    a_ctl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r8_ctl.wr && r8_ctl.smp))
        else $error("write and sample in one beat");

    // flagged result carries a zero pixel
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_pixel_value == '0)
        else $error("flagged result with non-zero pixel");

    // a stall freezes the pipeline tail
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_dq_ctl[HL-1]) && $stable(r12_ctl))
        else $error("pipeline moved during stall");

endmodule

// ===== tb/testbench.sv =====
// testbench: directed table and random traffic for the bilinear slice resampler
`timescale 1ns / 1ps
module testbench;

    localparam int X_W        = bsr_pkg::X_W;
    localparam int Y_W        = bsr_pkg::Y_W;
    localparam int Z_W        = bsr_pkg::Z_W;
    localparam int VOX_W      = bsr_pkg::VOX_W;
    localparam int DX_W       = bsr_pkg::DX_W;
    localparam int CFG_IDX_W  = bsr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = bsr_pkg::CFG_DATA_W;
    localparam int MAX_WIDTH  = bsr_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = bsr_pkg::MAX_HEIGHT;
    localparam int MAX_DEPTH  = bsr_pkg::MAX_DEPTH;
    localparam int MAX_DEST   = bsr_pkg::MAX_DEST;

    localparam bit CMD_WRITE  = 1'b0;
    localparam bit CMD_SAMPLE = 1'b1;
    localparam int PHASE_BEATS = 250;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 30;

    typedef struct {
        bit            cmd;
        bit [X_W-1:0]  wx;
        bit [Y_W-1:0]  wy;
        bit [Z_W-1:0]  wz;
        bit [7:0]      val;
        bit [Z_W-1:0]  slc;
        bit [DX_W-1:0] dx;
        bit [DX_W-1:0] dy;
    } t_beat;

    typedef struct {
        bit [7:0] pix;
        bit       err;
    } t_pixel;

    typedef struct {
        t_beat b;
        bit    known;
        bit [7:0] pix;
        bit    err;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_command;
    logic [X_W-1:0]        i_write_x;
    logic [Y_W-1:0]        i_write_y;
    logic [Z_W-1:0]        i_write_z;
    logic [VOX_W-1:0]      i_voxel_value;
    logic [Z_W-1:0]        i_slice;
    logic [DX_W-1:0]       i_dest_x;
    logic [DX_W-1:0]       i_dest_y;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [VOX_W-1:0]      o_pixel_value;
    logic                  o_range_error;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor state
    bit [7:0]  voxels  [65536];
    bit        written [65536];
    bit [6:0]  reg_sw, reg_sh;
    bit [4:0]  reg_sd;
    bit [10:0] reg_dw, reg_dh;
    t_pixel    pixel_q[$];
    int        errors;
    int        sent;
    bit        calm;
    bit        hold_req;
    t_row      rows[$];

    bilinear_slice_resampler_top DUT (.*);

    // clock
    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic longint unsigned clip(longint unsigned v, longint unsigned lo,
                                             longint unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic longint unsigned eff_sw(); return clip(reg_sw, 2, MAX_WIDTH); endfunction
    function automatic longint unsigned eff_sh(); return clip(reg_sh, 2, MAX_HEIGHT); endfunction
    function automatic longint unsigned eff_sd(); return clip(reg_sd, 1, MAX_DEPTH); endfunction
    function automatic longint unsigned eff_dw(); return clip(reg_dw, 2, MAX_DEST); endfunction
    function automatic longint unsigned eff_dh(); return clip(reg_dh, 2, MAX_DEST); endfunction

    function automatic int vox_addr(longint unsigned x, longint unsigned y, longint unsigned z);
        return int'((z * MAX_HEIGHT + y) * MAX_WIDTH + x);
    endfunction

    // cell index and offset along one axis
    function automatic void cell_of(input longint unsigned d, input longint unsigned s,
                                    input longint unsigned dn, output longint unsigned base,
                                    output longint unsigned off);
        longint unsigned num, den, c;
        num  = d * (s - 1);
        den  = dn - 1;
        c    = (num + den - 1) / den;
        base = (c > 0) ? c - 1 : 0;
        off  = num - base * den;
    endfunction

    function automatic bit sample_in_range(t_beat b);
        return b.slc < eff_sd() && b.dx < eff_dw() && b.dy < eff_dh();
    endfunction

    // interpolated pixel for a sample beat
    function automatic t_pixel resample(t_beat b);
        t_pixel r;
        longint unsigned i0, w, j0, h, hx, hy, sum;
        r.pix = '0;
        r.err = 1'b1;
        if (!sample_in_range(b)) return r;
        cell_of(b.dx, eff_sw(), eff_dw(), i0, w);
        cell_of(b.dy, eff_sh(), eff_dh(), j0, h);
        hx  = eff_dw() - 1;
        hy  = eff_dh() - 1;
        sum = (hx - w) * (hy - h) * voxels[vox_addr(i0, j0, b.slc)]
            + w * (hy - h) * voxels[vox_addr(i0 + 1, j0, b.slc)]
            + (hx - w) * h * voxels[vox_addr(i0, j0 + 1, b.slc)]
            + w * h * voxels[vox_addr(i0 + 1, j0 + 1, b.slc)];
        r.pix = 8'(sum / (hx * hy));
        r.err = 1'b0;
        return r;
    endfunction

    // update the volume copy or queue the expected pixel for an accepted beat
    function automatic void absorb_beat(t_beat b);
        if (b.cmd == CMD_WRITE) begin
            if (b.wx < eff_sw() && b.wy < eff_sh() && b.wz < eff_sd()) begin
                voxels[vox_addr(b.wx, b.wy, b.wz)]  = b.val;
                written[vox_addr(b.wx, b.wy, b.wz)] = 1'b1;
            end
        end else begin
            pixel_q.push_back(resample(b));
        end
    endfunction

    // offer one beat, with an optional gap first
    task automatic drive_beat(t_beat b);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_command     <= b.cmd;
        i_write_x     <= b.wx;
        i_write_y     <= b.wy;
        i_write_z     <= b.wz;
        i_voxel_value <= b.val;
        i_slice       <= b.slc;
        i_dest_x      <= b.dx;
        i_dest_y      <= b.dy;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_beat(b);
        sent++;
    endtask

    // write any unwritten neighbour the sample will read, then send the sample
    task automatic send_sample(t_beat b);
        longint unsigned i0, w, j0, h;
        t_beat f;
        if (sample_in_range(b)) begin
            cell_of(b.dx, eff_sw(), eff_dw(), i0, w);
            cell_of(b.dy, eff_sh(), eff_dh(), j0, h);
            for (int a = 0; a < 2; a++)
                for (int c = 0; c < 2; c++)
                    if (!written[vox_addr(i0 + a, j0 + c, b.slc)]) begin
                        f     = b;
                        f.cmd = CMD_WRITE;
                        f.wx  = X_W'(i0 + a);
                        f.wy  = Y_W'(j0 + c);
                        f.wz  = b.slc;
                        f.val = 8'($urandom);
                        drive_beat(f);
                    end
        end
        drive_beat(b);
    endtask

    task automatic send(t_beat b);
        if (b.cmd == CMD_SAMPLE) send_sample(b);
        else drive_beat(b);
    endtask

    // let the block drain before touching the registers
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pixel_q.size() == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            bsr_pkg::CFG_SRC_WIDTH:  reg_sw = data[6:0];
            bsr_pkg::CFG_SRC_HEIGHT: reg_sh = data[6:0];
            bsr_pkg::CFG_SRC_DEPTH:  reg_sd = data[4:0];
            bsr_pkg::CFG_DST_WIDTH:  reg_dw = data;
            bsr_pkg::CFG_DST_HEIGHT: reg_dh = data;
            default: ;
        endcase
    endtask

    task automatic set_sizes(int sw, int sh, int sd, int dw, int dh);
        wait_idle();
        cfg_write(bsr_pkg::CFG_SRC_WIDTH, CFG_DATA_W'(sw));
        cfg_write(bsr_pkg::CFG_SRC_HEIGHT, CFG_DATA_W'(sh));
        cfg_write(bsr_pkg::CFG_SRC_DEPTH, CFG_DATA_W'(sd));
        cfg_write(bsr_pkg::CFG_DST_WIDTH, CFG_DATA_W'(dw));
        cfg_write(bsr_pkg::CFG_DST_HEIGHT, CFG_DATA_W'(dh));
        // unused indexes must leave the sizes alone
        for (int k = int'(bsr_pkg::CFG_DST_HEIGHT) + 1; k < (1 << CFG_IDX_W); k++)
            cfg_write(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    endtask

    function automatic t_beat random_beat();
        t_beat b;
        b.cmd = $urandom_range(0, 2) != 0 ? CMD_SAMPLE : CMD_WRITE;
        b.wx  = X_W'($urandom);
        b.wy  = Y_W'($urandom);
        b.wz  = Z_W'($urandom);
        b.val = 8'($urandom);
        b.slc = Z_W'($urandom);
        b.dx  = DX_W'($urandom);
        b.dy  = DX_W'($urandom);
        if ($urandom_range(0, 9) != 0) begin
            b.wx  = X_W'($urandom_range(0, int'(eff_sw()) - 1));
            b.wy  = Y_W'($urandom_range(0, int'(eff_sh()) - 1));
            b.wz  = Z_W'($urandom_range(0, int'(eff_sd()) - 1));
            b.slc = Z_W'($urandom_range(0, int'(eff_sd()) - 1));
            b.dx  = DX_W'($urandom_range(0, int'(eff_dw()) - 1));
            b.dy  = DX_W'($urandom_range(0, int'(eff_dh()) - 1));
        end
        return b;
    endfunction

    // random traffic until n beats, fill writes included, have been accepted
    task automatic random_phase(int n, bit squeeze);
        int k;
        int stop;
        k    = 0;
        stop = sent + n;
        while (sent < stop) begin
            if (squeeze && k == 20) hold_req = 1'b1;
            send(random_beat());
            k++;
        end
    endtask

    function automatic t_row mk(bit cmd, int wx, int wy, int wz, int val, int slc,
                                int dx, int dy, bit known, int pix, bit err);
        t_row r;
        r.b.cmd = cmd;
        r.b.wx  = X_W'(wx);
        r.b.wy  = Y_W'(wy);
        r.b.wz  = Z_W'(wz);
        r.b.val = 8'(val);
        r.b.slc = Z_W'(slc);
        r.b.dx  = DX_W'(dx);
        r.b.dy  = DX_W'(dy);
        r.known = known;
        r.pix   = 8'(pix);
        r.err   = err;
        return r;
    endfunction

    // receiver: random stalls, plus one long hold on request
    initial begin
        int n;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                n = 0;
                while (n < LONG_HOLD) begin
                    @(negedge i_clk);
                    n++;
                end
                hold_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // pixel checker
    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_q.size() == 0) begin
                errors++;
                $display("%0t unexpected pixel: expected none, actual %0d/%0b",
                         $time, o_pixel_value, o_range_error);
            end else begin
                e = pixel_q.pop_front();
                if (o_pixel_value !== e.pix) begin
                    errors++;
                    $display("%0t pixel_value: expected %0d, actual %0d",
                             $time, e.pix, o_pixel_value);
                end
                if (o_range_error !== e.err) begin
                    errors++;
                    $display("%0t range_error: expected %0b, actual %0b",
                             $time, e.err, o_range_error);
                end
            end
        end
    end

    // stimulus
    initial begin
        t_pixel p;
        errors        = 0;
        sent          = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = CMD_WRITE;
        i_write_x     = '0;
        i_write_y     = '0;
        i_write_z     = '0;
        i_voxel_value = '0;
        i_slice       = '0;
        i_dest_x      = '0;
        i_dest_y      = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        reg_sw = 64; reg_sh = 64; reg_sd = 16; reg_dw = 64; reg_dh = 64;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed beats under the reset sizes
        rows.push_back(mk(CMD_WRITE, 0, 0, 0, 255, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_WRITE, 1, 0, 0, 255, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_WRITE, 0, 1, 0, 255, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_WRITE, 1, 1, 0, 255, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 1, 255, 0));
        rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 0, 1, 1, 1, 255, 0));
        rows.push_back(mk(CMD_WRITE, 62, 62, 15, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_WRITE, 63, 62, 15, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_WRITE, 62, 63, 15, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_WRITE, 63, 63, 15, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 15, 63, 63, 1, 0, 0));
        rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 0, 1023, 0, 1, 0, 1));
        rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 1023, 1, 0, 1));
        rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 15, 64, 5, 1, 0, 1));
        rows.push_back(mk(CMD_WRITE, 63, 0, 7, 170, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_WRITE, 0, 63, 8, 85, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 7, 63, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 8, 0, 63, 0, 0, 0));
        rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 0, 63, 63, 0, 0, 0));
        rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 7, 31, 32, 0, 0, 0));
        foreach (rows[k]) begin
            if (rows[k].known && rows[k].b.cmd == CMD_SAMPLE) begin
                p = resample(rows[k].b);
                if (p.pix !== rows[k].pix || p.err !== rows[k].err) begin
                    errors++;
                    $display("%0t table row %0d: expected %0d/%0b, actual %0d/%0b", $time,
                             k, rows[k].pix, rows[k].err, p.pix, p.err);
                end
            end
            send(rows[k].b);
        end
        random_phase(PHASE_BEATS, 1'b1);

        // sender waits for every pixel before the next sizes
        set_sizes(3, 5, 2, 7, 4);
        random_phase(PHASE_BEATS, 1'b0);
        set_sizes(0, 127, 0, 2047, 1);
        random_phase(PHASE_BEATS, 1'b0);
        set_sizes(64, 2, 31, 1024, 1024);
        random_phase(PHASE_BEATS, 1'b0);
        set_sizes(2, 2, 1, 2, 2);
        random_phase(PHASE_BEATS, 1'b0);
        set_sizes(17, 9, 5, 300, 33);
        random_phase(PHASE_BEATS, 1'b0);
        set_sizes(64, 64, 16, 3, 1000);
        random_phase(PHASE_BEATS / 2, 1'b0);
        calm = 1'b1;
        random_phase(PHASE_BEATS / 2, 1'b0);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pixel_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
